>>> hdl/bbc_pkg.sv
`timescale 1ns / 1ps

package bbc_pkg;

	// Defaults for the top-level parameters.
	localparam int unsigned      STACK_DEPTH  = 1024;
	localparam longint unsigned  MAX_POSITION = 65535;

	// Width of a position as it is reported and stored.
	localparam int unsigned POS_W = 16;

	localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28; // (
	localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29; // )
	localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B; // [
	localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D; // ]
	localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B; // {
	localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D; // }

	typedef enum logic [1:0] {
		KIND_ROUND  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		VERDICT_OK        = 2'd0,
		VERDICT_BAD_CLOSE = 2'd1,
		VERDICT_UNMATCHED = 2'd2,
		VERDICT_OVERFLOW  = 2'd3
	} verdict_t;

	// One stack entry: the bracket kind and its position.
	typedef struct packed {
		kind_t             kind;
		logic [POS_W-1:0]  pos;
	} entry_t;

	// Shift command given to every cell of the stack.
	typedef struct packed {
		logic push;
		logic pop;
	} stack_op_t;

	function automatic kind_t opening_kind(input logic [7:0] c);
		unique case (c)
			CHAR_ROUND_OPEN:  opening_kind = KIND_ROUND;
			CHAR_SQUARE_OPEN: opening_kind = KIND_SQUARE;
			CHAR_CURLY_OPEN:  opening_kind = KIND_CURLY;
			default:          opening_kind = KIND_NONE;
		endcase
	endfunction

	function automatic kind_t closing_kind(input logic [7:0] c);
		unique case (c)
			CHAR_ROUND_CLOSE:  closing_kind = KIND_ROUND;
			CHAR_SQUARE_CLOSE: closing_kind = KIND_SQUARE;
			CHAR_CURLY_CLOSE:  closing_kind = KIND_CURLY;
			default:           closing_kind = KIND_NONE;
		endcase
	endfunction

endpackage

>>> hdl/bbc_cell.sv
`timescale 1ns / 1ps

// One stack entry. A push takes the entry from the cell above, a pop the
// entry from the cell below.
module bbc_cell (
	input  logic                clk,
	input  bbc_pkg::stack_op_t  op,
	input  bbc_pkg::entry_t     from_above,
	input  bbc_pkg::entry_t     from_below,
	output bbc_pkg::entry_t     entry
);

	bbc_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (op.push) begin
			entry_q <= from_above;
		end else if (op.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

>>> hdl/bbc_stack.sv
`timescale 1ns / 1ps

// Shifting stack built as a row of cells. The top of stack always sits in
// cell 0, the entry beneath it in cell 1.
module bbc_stack #(
	parameter int unsigned STACK_DEPTH = bbc_pkg::STACK_DEPTH
) (
	input  logic                clk,
	input  bbc_pkg::stack_op_t  op,
	input  bbc_pkg::entry_t     push_entry,
	output bbc_pkg::entry_t     top,
	output bbc_pkg::entry_t     second
);

	bbc_pkg::entry_t cells [STACK_DEPTH];

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		bbc_pkg::entry_t above;
		bbc_pkg::entry_t below;

		if (i == 0) begin : g_head
			assign above = push_entry;
		end else begin : g_mid
			assign above = cells[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_tail
			assign below = bbc_pkg::entry_t'('0);
		end else begin : g_body
			assign below = cells[i+1];
		end

		bbc_cell u_cell (
			.clk        (clk),
			.op         (op),
			.from_above (above),
			.from_below (below),
			.entry      (cells[i])
		);
	end

	assign top    = cells[0];
	assign second = cells[1];

endmodule

>>> hdl/bracket_balance_checker.sv
`timescale 1ns / 1ps

// The result of a string is registered and appears on the output in the cycle after the transfer of its last byte.
// Throughput: one byte per cycle, sustained, while results are taken; each byte causes at most one push or pop.
// The figure is set by the shifting stack of cells, whose top entry is always in cell 0.
// Reset: arst_n clears counters, error state and the output valid flag at once; the stack cells
// are not reset and need no clearing pass, as only entries below the stack count are ever read.
module bracket_balance_checker #(
	parameter int unsigned     STACK_DEPTH  = bbc_pkg::STACK_DEPTH,
	parameter longint unsigned MAX_POSITION = bbc_pkg::MAX_POSITION
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                char_in,
	input  logic                      is_last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                verdict,
	output logic [bbc_pkg::POS_W-1:0] fault_position
);

	localparam int unsigned CNT_W  = $clog2(MAX_POSITION + 1);
	localparam int unsigned SCNT_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned POS_W  = bbc_pkg::POS_W;

	// Control state of the string being checked.
	logic [CNT_W-1:0]   char_count_q;
	logic [SCNT_W-1:0]  stack_count_q;
	logic               error_q;
	bbc_pkg::verdict_t  err_kind_q;
	logic [POS_W-1:0]   err_pos_q;

	// Output register.
	logic               out_valid_q;
	bbc_pkg::verdict_t  verdict_q;
	logic [POS_W-1:0]   fault_position_q;

	logic               accept;
	logic [CNT_W-1:0]   cnt_next;
	logic [POS_W-1:0]   pos_now;
	bbc_pkg::kind_t     open_k;
	bbc_pkg::kind_t     close_k;
	bbc_pkg::stack_op_t op;
	bbc_pkg::stack_op_t cell_op;
	logic               err_set;
	bbc_pkg::verdict_t  err_kind_new;
	logic [SCNT_W-1:0]  stack_count_next;
	bbc_pkg::entry_t    push_entry;
	bbc_pkg::entry_t    top;
	bbc_pkg::entry_t    second;
	logic [POS_W-1:0]   top_pos_after;
	bbc_pkg::verdict_t  res_verdict;
	logic [POS_W-1:0]   res_pos;

	// The output register frees up in the same cycle as its result is taken, so a new
	// byte is accepted even while a finished result is still waiting.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Positions saturate at the maximum; only the low bits are reported.
	assign cnt_next = (char_count_q < CNT_W'(MAX_POSITION)) ? char_count_q + 1'b1
	                                                        : char_count_q;
	assign pos_now  = POS_W'(cnt_next);

	assign open_k  = bbc_pkg::opening_kind(char_in);
	assign close_k = bbc_pkg::closing_kind(char_in);

	// Decide what this byte does to the stack. Once an error is latched, every later
	// byte of the string is only counted.
	always_comb begin
		op           = '0;
		err_set      = 1'b0;
		err_kind_new = bbc_pkg::VERDICT_BAD_CLOSE;
		if (!error_q) begin
			if (open_k != bbc_pkg::KIND_NONE) begin
				if (stack_count_q == SCNT_W'(STACK_DEPTH)) begin
					err_set      = 1'b1;
					err_kind_new = bbc_pkg::VERDICT_OVERFLOW;
				end else begin
					op.push = 1'b1;
				end
			end else if (close_k != bbc_pkg::KIND_NONE) begin
				if (stack_count_q == '0) begin
					err_set = 1'b1;
				end else if (top.kind == close_k) begin
					op.pop = 1'b1;
				end else begin
					err_set = 1'b1;
				end
			end
		end
	end

	assign cell_op         = accept ? op : '0;
	assign push_entry.kind = open_k;
	assign push_entry.pos  = pos_now;

	bbc_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk        (clk),
		.op         (cell_op),
		.push_entry (push_entry),
		.top        (top),
		.second     (second)
	);

	always_comb begin
		if (op.push) begin
			stack_count_next = stack_count_q + 1'b1;
			top_pos_after    = pos_now;
		end else if (op.pop) begin
			stack_count_next = stack_count_q - 1'b1;
			top_pos_after    = second.pos;
		end else begin
			stack_count_next = stack_count_q;
			top_pos_after    = top.pos;
		end
	end

	// Outcome of the string as it stands after this byte.
	always_comb begin
		if (error_q) begin
			res_verdict = err_kind_q;
			res_pos     = err_pos_q;
		end else if (err_set) begin
			res_verdict = err_kind_new;
			res_pos     = pos_now;
		end else if (stack_count_next == '0) begin
			res_verdict = bbc_pkg::VERDICT_OK;
			res_pos     = '0;
		end else begin
			res_verdict = bbc_pkg::VERDICT_UNMATCHED;
			res_pos     = top_pos_after;
		end
	end

	// String state. The last byte returns everything to its reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q  <= '0;
			stack_count_q <= '0;
			error_q       <= 1'b0;
			err_kind_q    <= bbc_pkg::VERDICT_OK;
			err_pos_q     <= '0;
		end else if (accept) begin
			if (is_last) begin
				char_count_q  <= '0;
				stack_count_q <= '0;
				error_q       <= 1'b0;
				err_kind_q    <= bbc_pkg::VERDICT_OK;
				err_pos_q     <= '0;
			end else begin
				char_count_q  <= cnt_next;
				stack_count_q <= stack_count_next;
				if (err_set) begin
					error_q    <= 1'b1;
					err_kind_q <= err_kind_new;
					err_pos_q  <= pos_now;
				end
			end
		end
	end

	// Output register: filled by the last byte of a string, emptied by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && is_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_last) begin
			verdict_q        <= res_verdict;
			fault_position_q <= res_pos;
		end
	end

	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign fault_position = fault_position_q;

	// The stack never holds more entries than it has cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stack_count_q <= SCNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// The last byte of a string always yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_last |=> out_valid)
		else $error("no result after last byte");

	// A byte that is not the last leaves a nonzero position count behind.
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_last |=> char_count_q != '0)
		else $error("position count did not advance");

	// Success carries no fault position.
	a_ok_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == bbc_pkg::VERDICT_OK |-> fault_position == '0)
		else $error("success with nonzero position");

endmodule
